// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by led_panel_test_pattern_gen.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lptpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lptpg_pkg
// Types, pattern codes and color tables of the LED panel test pattern gen.
// ----------------------------------------------------------------------------
package lptpg_pkg;

   localparam int COL_W = 8;
   localparam int ROW_W = 6;
   localparam int SEL_W = 4;
   localparam int CH_W  = 8;

   typedef enum logic [SEL_W-1:0] {
      PAT_BLEED    = 4'd0,
      PAT_HLINES   = 4'd1,
      PAT_ROW_TAIL = 4'd2,
      PAT_PANELS   = 4'd3,
      PAT_CHECKERS = 4'd4,
      PAT_RED      = 4'd5,
      PAT_GREEN    = 4'd6,
      PAT_BLUE     = 4'd7,
      PAT_BLACK    = 4'd8
   } pattern_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   localparam rgb_type RGB_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
   localparam rgb_type RGB_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
   localparam rgb_type RGB_RED   = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
   localparam rgb_type RGB_GREEN = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
   localparam rgb_type RGB_BLUE  = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};

   localparam rgb_type PANEL_RGB [4] = '{
      '{red: 8'd220, green: 8'd0,   blue: 8'd0},
      '{red: 8'd0,   green: 8'd210, blue: 8'd0},
      '{red: 8'd0,   green: 8'd70,  blue: 8'd255},
      '{red: 8'd0,   green: 8'd0,   blue: 8'd0}
   };

   localparam rgb_type TAIL_RGB [4] = '{
      '{red: 8'd255, green: 8'd190, blue: 8'd0},
      '{red: 8'd0,   green: 8'd255, blue: 8'd190},
      '{red: 8'd255, green: 8'd0,   blue: 8'd255},
      '{red: 8'd255, green: 8'd255, blue: 8'd255}
   };

   localparam rgb_type CHECK_RGB [4] = '{RGB_RED, RGB_GREEN, RGB_BLUE, RGB_WHITE};

   localparam rgb_type BAND_RGB [4] = '{RGB_RED, RGB_GREEN, RGB_BLUE, RGB_BLACK};

endpackage

// ===== rtl/lptpg_pattern.sv =====
// ----------------------------------------------------------------------------
// lptpg_pattern
// Pixel color for one coordinate under the selected test pattern.
// ----------------------------------------------------------------------------
module lptpg_pattern (
   input  logic [lptpg_pkg::SEL_W-1:0] pattern_select,
   input  logic [lptpg_pkg::COL_W-1:0] column,
   input  logic [lptpg_pkg::ROW_W-1:0] row,
   output lptpg_pkg::rgb_type          pixel
);
   import lptpg_pkg::*;

   logic [1:0] panel;
   logic [5:0] local_x;
   logic       tail_rows;
   logic       side_band;
   logic       tail_black;
   logic [1:0] band;
   logic [2:0] phase;
   logic       odd_square;

   always_comb begin
      panel      = column[7:6];
      local_x    = column[5:0];
      tail_rows  = (row[5:3] == 3'd3) || (row[5:3] == 3'd7);
      side_band  = (local_x < 6'd4) || (local_x >= 6'd60);
      odd_square = local_x[3] ^ row[3];
      phase      = row[2:0] + {1'b0, panel};
      tail_black = (local_x == 6'd0) || (local_x == 6'd63) || (row == 6'd31) ||
                   (row == 6'd32) || (tail_rows && (local_x[3:0] == 4'd8));

      if (row[5:3] == 3'd7) begin
         band = column[1:0] + row[1:0];
      end else if (row[5:3] == 3'd6) begin
         band = column[1:0];
      end else begin
         band = column[4:3];
      end

      unique case (pattern_select)
         PAT_RED:      pixel = RGB_RED;
         PAT_GREEN:    pixel = RGB_GREEN;
         PAT_BLUE:     pixel = RGB_BLUE;
         PAT_BLACK:    pixel = RGB_BLACK;
         PAT_PANELS:   pixel = PANEL_RGB[panel];
         PAT_CHECKERS: pixel = odd_square ? RGB_BLACK : CHECK_RGB[panel];
         PAT_BLEED:    pixel = BAND_RGB[band];
         PAT_HLINES: begin
            if (side_band) begin
               pixel = PANEL_RGB[panel];
            end else if (phase < 3'd3) begin
               pixel = BAND_RGB[phase[1:0]];
            end else if (phase == 3'd4) begin
               pixel = RGB_WHITE;
            end else begin
               pixel = RGB_BLACK;
            end
         end
         // row tail, also for unassigned codes
         default: begin
            if (tail_black) begin
               pixel = RGB_BLACK;
            end else if (tail_rows) begin
               pixel = TAIL_RGB[panel];
            end else begin
               pixel = PANEL_RGB[panel];
            end
         end
      endcase
   end

endmodule

// ===== rtl/led_panel_test_pattern_gen.sv =====
// ----------------------------------------------------------------------------
// led_panel_test_pattern_gen
// RGB888 test pattern pixel for a coordinate on four chained 64x64 panels.
// ----------------------------------------------------------------------------
//   channel | direction | word
//   req_    | in        | req_column, req_row
//   rsp_    | out       | rsp_red, rsp_green, rsp_blue
//   csr_    | in        | csr_pattern_select
//
// One word per cycle sustained while rsp_ready is high; a word passes the
// coordinate register, then pattern logic into the result register.
// Reset clears both valid flags and sets the pattern select to bleed.
// With rsp_ready low the result holds; one more word is taken into the
// coordinate register, then req_ready drops. csr_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_panel_test_pattern_gen (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lptpg_pkg::COL_W-1:0] req_column,
   input  logic [lptpg_pkg::ROW_W-1:0] req_row,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lptpg_pkg::CH_W-1:0]  rsp_red,
   output logic [lptpg_pkg::CH_W-1:0]  rsp_green,
   output logic [lptpg_pkg::CH_W-1:0]  rsp_blue,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lptpg_pkg::SEL_W-1:0] csr_pattern_select
);
   import lptpg_pkg::*;

   logic [SEL_W-1:0] pattern_ff;
   logic [SEL_W-1:0] pattern_in;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [COL_W-1:0] column_ff;
   logic [ROW_W-1:0] row_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rgb_type          result_ff;
   rgb_type          pixel;
   logic             s1_load;
   logic             s2_load;

   assign csr_ready = 1'b1;

   assign s2_load = !rsp_valid_ff || rsp_ready;
   assign s1_load = !s1_valid_ff || s2_load;

   always_comb begin
      pattern_in   = (csr_valid && csr_ready) ? csr_pattern_select : pattern_ff;
      s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
      rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= PAT_BLEED;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_load) begin
         column_ff <= req_column;
         row_ff    <= req_row;
      end
      if (s1_valid_ff && s2_load) begin
         result_ff <= pixel;
      end
   end

   lptpg_pattern u_pattern (
      .pattern_select (pattern_ff),
      .column         (column_ff),
      .row            (row_ff),
      .pixel          (pixel)
   );

   assign req_ready = s1_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = result_ff.red;
   assign rsp_green = result_ff.green;
   assign rsp_blue  = result_ff.blue;

   `ASSERT_NEXT(a_req_enters_s1, clock, reset, req_valid && req_ready, s1_valid_ff, "accepted word lost before stage 1")
   `ASSERT_NEXT(a_s1_reaches_rsp, clock, reset, s1_valid_ff && s2_load, rsp_valid, "stage 1 word did not reach result")
   `ASSERT_IMPL(a_no_bubble_stall, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff, "input stalled with free stage")
   `ASSERT_NEXT(a_solid_red, clock, reset, s1_valid_ff && s2_load && (pattern_ff == PAT_RED), (rsp_red == 8'd255) && (rsp_green == 8'd0) && (rsp_blue == 8'd0), "solid red pattern wrong")

endmodule
